### rtl/core/servo_light_hill_climb_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the servo light hill-climb tracker
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_LIGHT_HILL_CLIMB_TRACKER_CORE_MACROS_SVH
`define SERVO_LIGHT_HILL_CLIMB_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define STLHC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stlhc assertion failed");

// Next-cycle implication, disabled while reset is low
`define STLHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stlhc assertion failed");

`endif

### rtl/core/stlhc_pkg.sv
// ----------------------------------------------------------------------------
// stlhc_pkg
// Types, register indexes and reset values of the light hill-climb tracker.
// ----------------------------------------------------------------------------
package stlhc_pkg;

    // Fixed field widths
    localparam int STEP_WIDTH      = 8;
    localparam int CFG_INDEX_WIDTH = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_SIZE        = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DUTY_LOW_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DUTY_HIGH_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DUTY_CENTER      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_CENTER_LIMIT = 3'd4;

    // Reset values, cut to the duty width where used
    localparam logic [STEP_WIDTH-1:0] STEP_SIZE_RST        = 8'd50;
    localparam logic [15:0]           DUTY_LOW_LIMIT_RST   = 16'd700;
    localparam logic [15:0]           DUTY_HIGH_LIMIT_RST  = 16'd2200;
    localparam logic [15:0]           DUTY_CENTER_RST      = 16'd1450;
    localparam logic [15:0]           OFF_CENTER_LIMIT_RST = 16'd200;

    // Request codes
    localparam logic REQ_SAMPLE   = 1'b0;
    localparam logic REQ_RECENTER = 1'b1;

    // Search phase
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_UP_FIRST = 3'd1,
        PH_UP       = 3'd2,
        PH_DOWN_REF = 3'd3,
        PH_DOWN     = 3'd4
    } t_phase;

    // Duty move chosen for a sample
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_UP,
        ACT_DOWN
    } t_act;

    // Sequencer states
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_STEP,
        SQ_CLAMP,
        SQ_DIFF,
        SQ_ABS,
        SQ_DIV,
        SQ_REDUCE,
        SQ_OFF_DIFF,
        SQ_OFF_ABS,
        SQ_OFF_CMP,
        SQ_LOAD
    } t_seq;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

### rtl/core/stlhc_alu.sv
// ----------------------------------------------------------------------------
// stlhc_alu
// Shared two's complement add/subtract unit of the tracker sequencer.
// ----------------------------------------------------------------------------
module stlhc_alu #(
    parameter int WIDTH = 14
) (
    input  logic [WIDTH-1:0] i_a,
    input  stlhc_pkg::t_alu_op i_op,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_res
);

    // Add or subtract, result wraps at WIDTH bits
    always_comb begin
        case (i_op)
            stlhc_pkg::ALU_SUB: o_res = i_a - i_b;
            default:            o_res = i_a + i_b;
        endcase
    end

endmodule

### rtl/core/servo_light_hill_climb_tracker_core.sv
// A sample that ends the search runs the off-center checks and the load step; one
// that moves the duty first steps and clamps it. A recenter divides its offset from
// center by the step (restoring divider, one bit per cycle, skipped for a zero step)
// and reduces the duty. One item at a time, the next taken the cycle after loading.
// A stalled result holds the sequencer in its load step until the output frees up.
// Reset (synchronous, active low) restores register defaults, idle phase, center duty.
// ----------------------------------------------------------------------------
// servo_light_hill_climb_tracker_core
// Hill-climb duty tracker built around one shared adder and a small sequencer.
// ----------------------------------------------------------------------------
module servo_light_hill_climb_tracker_core #(
    parameter int DUTY_WIDTH   = 12,
    parameter int SAMPLE_WIDTH = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_wr_en,
    input  logic [stlhc_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [DUTY_WIDTH-1:0]                  i_cfg_data,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_req_type,
    input  logic [SAMPLE_WIDTH-1:0]                i_light_sample,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [DUTY_WIDTH-1:0]                  o_duty_command,
    output logic                                   o_search_done,
    output logic [DUTY_WIDTH-1:0]                  o_turn_steps,
    output logic                                   o_turn_left,
    output logic                                   o_off_center
);

    localparam int SW    = stlhc_pkg::STEP_WIDTH;
    localparam int AW    = DUTY_WIDTH + 2;
    localparam int CNT_W = $clog2(DUTY_WIDTH);

    // Configuration registers
    logic [SW-1:0]         r_step_size;
    logic [DUTY_WIDTH-1:0] r_low_limit;
    logic [DUTY_WIDTH-1:0] r_high_limit;
    logic [DUTY_WIDTH-1:0] r_center;
    logic [DUTY_WIDTH-1:0] r_off_limit;

    // Tracker state
    stlhc_pkg::t_phase       r_phase, n_phase;
    logic [DUTY_WIDTH-1:0]   r_duty;
    logic [SAMPLE_WIDTH-1:0] r_ref, n_ref;

    // Sequencer and working registers
    stlhc_pkg::t_seq       r_state, n_state;
    stlhc_pkg::t_act       r_act, n_act;
    logic                  r_req;
    logic                  r_done, n_done;
    logic [AW-1:0]         r_acc;
    logic [SW-1:0]         r_rem;
    logic [DUTY_WIDTH-1:0] r_quo;
    logic                  r_neg;
    logic                  r_off;
    logic [CNT_W-1:0]      r_cnt;

    // Output register
    logic                  r_out_valid;
    logic [DUTY_WIDTH-1:0] r_out_duty;
    logic                  r_out_done;
    logic [DUTY_WIDTH-1:0] r_out_turn;
    logic                  r_out_left;
    logic                  r_out_off;

    // Shared adder
    logic [AW-1:0]       alu_a, alu_b, alu_res;
    stlhc_pkg::t_alu_op  alu_op;
    logic                alu_neg;

    logic in_xfer, out_free, step_zero, brighter;
    logic [SW:0] div_shift;

    assign in_xfer   = i_in_valid && (r_state == stlhc_pkg::SQ_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign step_zero = (r_step_size == '0);
    assign brighter  = r_ref < i_light_sample;
    assign alu_neg   = alu_res[AW-1];
    assign div_shift = {r_rem, r_quo[DUTY_WIDTH-1]};

    stlhc_alu #(.WIDTH(AW)) u_alu (
        .i_a   (alu_a),
        .i_op  (alu_op),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Decode the phase move for an incoming item
    always_comb begin
        n_phase = r_phase;
        n_ref   = r_ref;
        n_act   = stlhc_pkg::ACT_NONE;
        n_done  = 1'b0;
        if (i_req_type == stlhc_pkg::REQ_RECENTER) begin
            n_phase = stlhc_pkg::PH_IDLE;
        end else begin
            case (r_phase)
                stlhc_pkg::PH_UP_FIRST: begin
                    if (brighter) begin
                        n_ref   = i_light_sample;
                        n_act   = stlhc_pkg::ACT_UP;
                        n_phase = stlhc_pkg::PH_UP;
                    end else begin
                        n_act   = stlhc_pkg::ACT_DOWN;
                        n_phase = stlhc_pkg::PH_DOWN_REF;
                    end
                end
                stlhc_pkg::PH_UP: begin
                    if (brighter) begin
                        n_ref = i_light_sample;
                        n_act = stlhc_pkg::ACT_UP;
                    end else begin
                        n_done  = 1'b1;
                        n_phase = stlhc_pkg::PH_IDLE;
                    end
                end
                stlhc_pkg::PH_DOWN_REF: begin
                    n_ref   = i_light_sample;
                    n_act   = stlhc_pkg::ACT_DOWN;
                    n_phase = stlhc_pkg::PH_DOWN;
                end
                stlhc_pkg::PH_DOWN: begin
                    if (brighter) begin
                        n_ref = i_light_sample;
                        n_act = stlhc_pkg::ACT_DOWN;
                    end else begin
                        n_done  = 1'b1;
                        n_phase = stlhc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_ref   = i_light_sample;
                    n_act   = stlhc_pkg::ACT_UP;
                    n_phase = stlhc_pkg::PH_UP_FIRST;
                end
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stlhc_pkg::SQ_IDLE: begin
                if (in_xfer) begin
                    if (i_req_type == stlhc_pkg::REQ_RECENTER) begin
                        n_state = stlhc_pkg::SQ_DIFF;
                    end else if (n_act == stlhc_pkg::ACT_NONE) begin
                        n_state = stlhc_pkg::SQ_OFF_DIFF;
                    end else begin
                        n_state = stlhc_pkg::SQ_STEP;
                    end
                end
            end
            stlhc_pkg::SQ_STEP:     n_state = stlhc_pkg::SQ_CLAMP;
            stlhc_pkg::SQ_CLAMP:    n_state = stlhc_pkg::SQ_OFF_DIFF;
            stlhc_pkg::SQ_DIFF:     n_state = stlhc_pkg::SQ_ABS;
            stlhc_pkg::SQ_ABS: begin
                n_state = step_zero ? stlhc_pkg::SQ_REDUCE : stlhc_pkg::SQ_DIV;
            end
            stlhc_pkg::SQ_DIV: begin
                if (r_cnt == '0) begin
                    n_state = stlhc_pkg::SQ_REDUCE;
                end
            end
            stlhc_pkg::SQ_REDUCE:   n_state = stlhc_pkg::SQ_OFF_DIFF;
            stlhc_pkg::SQ_OFF_DIFF: n_state = stlhc_pkg::SQ_OFF_ABS;
            stlhc_pkg::SQ_OFF_ABS:  n_state = stlhc_pkg::SQ_OFF_CMP;
            stlhc_pkg::SQ_OFF_CMP:  n_state = stlhc_pkg::SQ_LOAD;
            stlhc_pkg::SQ_LOAD: begin
                if (out_free) begin
                    n_state = stlhc_pkg::SQ_IDLE;
                end
            end
            default: n_state = stlhc_pkg::SQ_IDLE;
        endcase
    end

    // Steer the shared adder for each sequencer step
    always_comb begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = stlhc_pkg::ALU_ADD;
        case (r_state)
            stlhc_pkg::SQ_STEP: begin
                alu_a  = {2'b00, r_duty};
                alu_b  = {{(AW-SW){1'b0}}, r_step_size};
                alu_op = (r_act == stlhc_pkg::ACT_UP) ? stlhc_pkg::ALU_ADD
                                                      : stlhc_pkg::ALU_SUB;
            end
            stlhc_pkg::SQ_CLAMP: begin
                alu_op = stlhc_pkg::ALU_SUB;
                if (r_act == stlhc_pkg::ACT_UP) begin
                    alu_a = r_acc;
                    alu_b = {2'b00, r_high_limit};
                end else begin
                    alu_a = {2'b00, r_low_limit};
                    alu_b = r_acc;
                end
            end
            stlhc_pkg::SQ_DIFF, stlhc_pkg::SQ_OFF_DIFF: begin
                alu_a  = {2'b00, r_duty};
                alu_b  = {2'b00, r_center};
                alu_op = stlhc_pkg::ALU_SUB;
            end
            stlhc_pkg::SQ_ABS, stlhc_pkg::SQ_OFF_ABS: begin
                if (r_acc[AW-1]) begin
                    alu_b  = r_acc;
                    alu_op = stlhc_pkg::ALU_SUB;
                end else begin
                    alu_a = r_acc;
                end
            end
            stlhc_pkg::SQ_DIV: begin
                alu_a  = {{(AW-SW-1){1'b0}}, div_shift};
                alu_b  = {{(AW-SW){1'b0}}, r_step_size};
                alu_op = stlhc_pkg::ALU_SUB;
            end
            stlhc_pkg::SQ_REDUCE: begin
                alu_a  = {2'b00, r_center};
                alu_b  = step_zero ? r_acc : {{(AW-SW){1'b0}}, r_rem};
                alu_op = r_neg ? stlhc_pkg::ALU_SUB : stlhc_pkg::ALU_ADD;
            end
            stlhc_pkg::SQ_OFF_CMP: begin
                alu_a  = {2'b00, r_off_limit};
                alu_b  = r_acc;
                alu_op = stlhc_pkg::ALU_SUB;
            end
            default: begin
                alu_op = stlhc_pkg::ALU_ADD;
            end
        endcase
    end

    // Control and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stlhc_pkg::SQ_IDLE;
            r_phase      <= stlhc_pkg::PH_IDLE;
            r_duty       <= stlhc_pkg::DUTY_CENTER_RST[DUTY_WIDTH-1:0];
            r_ref        <= '0;
            r_out_valid  <= 1'b0;
            r_step_size  <= stlhc_pkg::STEP_SIZE_RST;
            r_low_limit  <= stlhc_pkg::DUTY_LOW_LIMIT_RST[DUTY_WIDTH-1:0];
            r_high_limit <= stlhc_pkg::DUTY_HIGH_LIMIT_RST[DUTY_WIDTH-1:0];
            r_center     <= stlhc_pkg::DUTY_CENTER_RST[DUTY_WIDTH-1:0];
            r_off_limit  <= stlhc_pkg::OFF_CENTER_LIMIT_RST[DUTY_WIDTH-1:0];
        end else begin
            r_state <= n_state;

            // write configuration
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    stlhc_pkg::REG_STEP_SIZE:        r_step_size  <= i_cfg_data[SW-1:0];
                    stlhc_pkg::REG_DUTY_LOW_LIMIT:   r_low_limit  <= i_cfg_data;
                    stlhc_pkg::REG_DUTY_HIGH_LIMIT:  r_high_limit <= i_cfg_data;
                    stlhc_pkg::REG_DUTY_CENTER:      r_center     <= i_cfg_data;
                    stlhc_pkg::REG_OFF_CENTER_LIMIT: r_off_limit  <= i_cfg_data;
                    default: ;
                endcase
            end

            // advance phase and reference on transfer
            if (in_xfer) begin
                r_phase <= n_phase;
                r_ref   <= n_ref;
            end

            // take the clamped or reduced duty
            if (r_state == stlhc_pkg::SQ_CLAMP) begin
                if (!alu_neg) begin
                    r_duty <= (r_act == stlhc_pkg::ACT_UP) ? r_high_limit : r_low_limit;
                end else begin
                    r_duty <= r_acc[DUTY_WIDTH-1:0];
                end
            end
            if (r_state == stlhc_pkg::SQ_REDUCE) begin
                r_duty <= alu_res[DUTY_WIDTH-1:0];
            end

            // output register: drop on transfer, load when free
            if (r_state == stlhc_pkg::SQ_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            stlhc_pkg::SQ_IDLE: begin
                if (in_xfer) begin
                    r_req  <= i_req_type;
                    r_act  <= n_act;
                    r_done <= n_done;
                end
            end
            stlhc_pkg::SQ_STEP, stlhc_pkg::SQ_DIFF, stlhc_pkg::SQ_OFF_DIFF,
            stlhc_pkg::SQ_OFF_ABS: begin
                r_acc <= alu_res;
            end
            stlhc_pkg::SQ_ABS: begin
                r_acc <= alu_res;
                r_neg <= r_acc[AW-1];
                r_quo <= alu_res[DUTY_WIDTH-1:0];
                r_rem <= '0;
                r_cnt <= CNT_W'(DUTY_WIDTH - 1);
            end
            stlhc_pkg::SQ_DIV: begin
                // restoring division, one quotient bit per cycle
                r_rem <= alu_neg ? div_shift[SW-1:0] : alu_res[SW-1:0];
                r_quo <= {r_quo[DUTY_WIDTH-2:0], !alu_neg};
                r_cnt <= r_cnt - 1'b1;
            end
            stlhc_pkg::SQ_REDUCE: begin
                if (step_zero) begin
                    r_quo <= '0;
                end
            end
            stlhc_pkg::SQ_OFF_CMP: begin
                r_off <= alu_neg;
            end
            default: ;
        endcase

        // load the result
        if (r_state == stlhc_pkg::SQ_LOAD && out_free) begin
            r_out_duty <= r_req ? r_center : r_duty;
            r_out_done <= r_done;
            r_out_turn <= r_req ? r_quo : '0;
            r_out_left <= r_req && !r_neg && (r_quo != '0);
            r_out_off  <= r_off;
        end
    end

    assign o_in_stall     = (r_state != stlhc_pkg::SQ_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_duty_command = r_out_duty;
    assign o_search_done  = r_out_done;
    assign o_turn_steps   = r_out_turn;
    assign o_turn_left    = r_out_left;
    assign o_off_center   = r_out_off;

endmodule

### rtl/core/stlhc_checker.sv
// ----------------------------------------------------------------------------
// stlhc_checker
// Port-level checks of the tracker core, bound to the core module.
// ----------------------------------------------------------------------------
`include "servo_light_hill_climb_tracker_core_macros.svh"

module stlhc_checker #(
    parameter int DUTY_WIDTH = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DUTY_WIDTH-1:0] o_duty_command,
    input logic                  o_search_done,
    input logic [DUTY_WIDTH-1:0] o_turn_steps,
    input logic                  o_turn_left,
    input logic                  o_off_center
);

    // A stalled result holds
    `STLHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_duty_command) && $stable(o_turn_steps) && $stable(o_off_center))

    // One item at a time: busy right after a transfer
    `STLHC_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // Turn steps only come from a recenter, which never ends a search
    `STLHC_ASSERT_NOW(a_turn_not_done, i_clk, i_rst_n, o_out_valid && (o_turn_steps != '0), !o_search_done)

    // A left turn always carries a nonzero count
    `STLHC_ASSERT_NOW(a_left_has_steps, i_clk, i_rst_n, o_out_valid && o_turn_left, (o_turn_steps != '0) && !o_search_done)

endmodule

bind servo_light_hill_climb_tracker_core stlhc_checker #(
    .DUTY_WIDTH(DUTY_WIDTH)
) u_stlhc_checker (.*);

### dv/servo_light_hill_climb_tracker_core_test.sv
// ----------------------------------------------------------------------------
// servo_light_hill_climb_tracker_core_test
// Self-checking bench for the hill-climb duty tracker. A scoreboard class
// predicts each duty command from the accepted requests and checks every
// result in order. Both channels idle and stall at random. The register
// settings change between phases: default, zero step, widest step,
// crossed limits and limits pinned at the top and at zero.
// ----------------------------------------------------------------------------
module servo_light_hill_climb_tracker_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_MASK     = 'hFFF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 250;
    localparam int NUM_PHASES    = 8;

    // One result as seen on the output channel
    typedef struct packed {
        logic [11:0] duty_cmd;
        logic        done;
        logic [11:0] steps;
        logic        left;
        logic        off;
    } t_tracker_result;

    // Predictor of the tracker plus the queue of commands still awaited
    class hill_climb_scoreboard;
        int                step_size;
        int                low_limit;
        int                high_limit;
        int                center;
        int                off_limit;
        stlhc_pkg::t_phase phase;
        int                duty;
        int                ref_light;
        t_tracker_result   awaited_commands[$];
        int                errors;
        int                results;
        int                requests;
        int                recenters;
        int                peaks;

        function new();
            step_size  = stlhc_pkg::STEP_SIZE_RST;
            low_limit  = stlhc_pkg::DUTY_LOW_LIMIT_RST & DUTY_MASK;
            high_limit = stlhc_pkg::DUTY_HIGH_LIMIT_RST & DUTY_MASK;
            center     = stlhc_pkg::DUTY_CENTER_RST & DUTY_MASK;
            off_limit  = stlhc_pkg::OFF_CENTER_LIMIT_RST & DUTY_MASK;
            phase      = stlhc_pkg::PH_IDLE;
            duty       = stlhc_pkg::DUTY_CENTER_RST & DUTY_MASK;
            ref_light  = 0;
        endfunction

        function void write_reg(logic [stlhc_pkg::CFG_INDEX_WIDTH-1:0] idx, int value);
            case (idx)
                stlhc_pkg::REG_STEP_SIZE:        step_size  = value & 'hFF;
                stlhc_pkg::REG_DUTY_LOW_LIMIT:   low_limit  = value & DUTY_MASK;
                stlhc_pkg::REG_DUTY_HIGH_LIMIT:  high_limit = value & DUTY_MASK;
                stlhc_pkg::REG_DUTY_CENTER:      center     = value & DUTY_MASK;
                stlhc_pkg::REG_OFF_CENTER_LIMIT: off_limit  = value & DUTY_MASK;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_commands.size();
        endfunction

        // Step up, clamped at the high limit
        function void climb();
            int d;
            d = duty + step_size;
            if (d >= high_limit) d = high_limit;
            duty = d & DUTY_MASK;
        endfunction

        // Step down, clamped at the low limit
        function void descend();
            int d;
            d = duty - step_size;
            if (d <= low_limit) d = low_limit;
            duty = d & DUTY_MASK;
        endfunction

        // Work out the command caused by one accepted request
        function void predict_request(logic req, logic [9:0] light);
            t_tracker_result r;
            int  diff;
            int  n;
            int  light_level;
            bit  brighter;
            r = '0;
            light_level = light;
            requests++;
            if (req == stlhc_pkg::REQ_RECENTER) begin
                recenters++;
                diff = duty - center;
                n = (step_size != 0) ? diff / step_size : 0;
                duty = (diff - n * step_size + center) & DUTY_MASK;
                r.left  = (n > 0);
                if (n < 0) n = -n;
                r.steps = (n > 4095) ? 12'd4095 : 12'(n);
                phase = stlhc_pkg::PH_IDLE;
                r.duty_cmd = 12'(center);
            end else begin
                brighter = ref_light < light_level;
                case (phase)
                    stlhc_pkg::PH_UP_FIRST: begin
                        if (brighter) begin
                            ref_light = light_level;
                            climb();
                            phase = stlhc_pkg::PH_UP;
                        end else begin
                            descend();
                            phase = stlhc_pkg::PH_DOWN_REF;
                        end
                    end
                    stlhc_pkg::PH_UP: begin
                        if (brighter) begin
                            ref_light = light_level;
                            climb();
                        end else begin
                            r.done = 1'b1;
                            phase = stlhc_pkg::PH_IDLE;
                        end
                    end
                    stlhc_pkg::PH_DOWN_REF: begin
                        ref_light = light_level;
                        descend();
                        phase = stlhc_pkg::PH_DOWN;
                    end
                    stlhc_pkg::PH_DOWN: begin
                        if (brighter) begin
                            ref_light = light_level;
                            descend();
                        end else begin
                            r.done = 1'b1;
                            phase = stlhc_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        ref_light = light_level;
                        climb();
                        phase = stlhc_pkg::PH_UP_FIRST;
                    end
                endcase
                r.duty_cmd = 12'(duty);
            end
            diff = duty - center;
            if (diff < 0) diff = -diff;
            r.off = (diff > off_limit);
            awaited_commands.push_back(r);
        endfunction

        task report_mismatch(string field, logic [11:0] got, logic [11:0] want);
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, field, got,
                     want);
            errors++;
        endtask

        // Compare one result with the oldest awaited command
        task check_command(t_tracker_result got);
            t_tracker_result want;
            if (awaited_commands.size() == 0) begin
                report_mismatch("result with no request outstanding", got.duty_cmd, '0);
                return;
            end
            want = awaited_commands.pop_front();
            results++;
            if (want.done) peaks++;
            if (got.duty_cmd !== want.duty_cmd)
                report_mismatch("duty_command", got.duty_cmd, want.duty_cmd);
            if (got.done !== want.done)
                report_mismatch("search_done", 12'(got.done), 12'(want.done));
            if (got.steps !== want.steps)
                report_mismatch("turn_steps", got.steps, want.steps);
            if (got.left !== want.left)
                report_mismatch("turn_left", 12'(got.left), 12'(want.left));
            if (got.off !== want.off)
                report_mismatch("off_center", 12'(got.off), 12'(want.off));
        endtask
    endclass

    logic                                  i_clk          = 1'b0;
    logic                                  i_rst_n        = 1'b0;
    logic                                  i_cfg_wr_en    = 1'b0;
    logic [stlhc_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index    = '0;
    logic [11:0]                           i_cfg_data     = '0;
    logic                                  i_in_valid     = 1'b0;
    logic                                  o_in_stall;
    logic                                  i_req_type     = stlhc_pkg::REQ_SAMPLE;
    logic [9:0]                            i_light_sample = '0;
    logic                                  o_out_valid;
    logic                                  i_out_stall    = 1'b0;
    logic [11:0]                           o_duty_command;
    logic                                  o_search_done;
    logic [11:0]                           o_turn_steps;
    logic                                  o_turn_left;
    logic                                  o_off_center;

    hill_climb_scoreboard sb = new();
    bit calm       = 1'b0;
    int last_light = 0;
    int cycle_count = 0;

    // Directed opening: climb to a peak, descend to a peak, abandon a search
    localparam int DIRECTED_ITEMS = 22;
    logic       dir_req   [DIRECTED_ITEMS] = '{
        stlhc_pkg::REQ_RECENTER, stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE,
        stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE,
        stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE,
        stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_RECENTER,
        stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE,
        stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_SAMPLE,
        stlhc_pkg::REQ_SAMPLE, stlhc_pkg::REQ_RECENTER, stlhc_pkg::REQ_SAMPLE,
        stlhc_pkg::REQ_SAMPLE
    };
    logic [9:0] dir_light [DIRECTED_ITEMS] = '{
        10'd1023, 10'd0, 10'd1023, 10'd1023, 10'd500, 10'd400,
        10'd300, 10'd301, 10'd301, 10'd10, 10'd20, 10'd0,
        10'd0, 10'd0, 10'd0, 10'd1, 10'd2, 10'd3,
        10'd3, 10'd682, 10'd1023, 10'd1023
    };

    servo_light_hill_climb_tracker_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_light_sample (i_light_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_duty_command (o_duty_command),
        .o_search_done  (o_search_done),
        .o_turn_steps   (o_turn_steps),
        .o_turn_left    (o_turn_left),
        .o_off_center   (o_off_center)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stall the output channel at random outside calm stretches
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 32);
    end

    // Watch both channels: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.predict_request(i_req_type, i_light_sample);
            if (o_out_valid && !i_out_stall)
                sb.check_command('{o_duty_command, o_search_done, o_turn_steps,
                                   o_turn_left, o_off_center});
        end
    end

    // Present one request and hold it until the transfer
    task automatic send_request(input logic req, input logic [9:0] light);
        while (!calm && $urandom_range(0, 99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_light_sample <= light;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Mostly rising brightness so searches run deep, plus flat and random samples
    task automatic send_random_request();
        int pick;
        int level;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_request(stlhc_pkg::REQ_RECENTER, 10'($urandom));
            return;
        end
        if (pick < 70) begin
            level = last_light + $urandom_range(1, 60);
            if (level > 1023) level = $urandom_range(0, 200);
        end else if (pick < 80) begin
            level = last_light;
        end else begin
            level = $urandom_range(0, 1023);
        end
        last_light = level;
        send_request(stlhc_pkg::REQ_SAMPLE, 10'(level));
    endtask

    // Drop valid and hold until every awaited command has arrived
    task automatic wait_for_results(input int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [stlhc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 12'(value);
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(input int step, input int low, input int high,
                                  input int mid, input int limit);
        write_register(stlhc_pkg::REG_STEP_SIZE, step);
        write_register(stlhc_pkg::REG_DUTY_LOW_LIMIT, low);
        write_register(stlhc_pkg::REG_DUTY_HIGH_LIMIT, high);
        write_register(stlhc_pkg::REG_DUTY_CENTER, mid);
        write_register(stlhc_pkg::REG_OFF_CENTER_LIMIT, limit);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings
        for (int d = 0; d < DIRECTED_ITEMS; d++)
            send_request(dir_req[d], dir_light[d]);

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_results(SETTLE_CYCLES);
            case (p)
                0: apply_settings(0, 700, 2200, $urandom_range(0, 4095),
                                  $urandom_range(0, 400));
                1: apply_settings('hFFF, 0, 4095, 2048, 0);
                2: apply_settings($urandom_range(1, 255), 3000, 1000,
                                  $urandom_range(0, 4095), $urandom_range(0, 4095));
                3: apply_settings(1, 0, 4095, 0, 4095);
                4: apply_settings(255, 4095, 4095, 4095, 0);
                5: apply_settings(1, 0, 0, 4095, $urandom_range(0, 4095));
                default: apply_settings($urandom_range(1, 255), $urandom_range(0, 2000),
                                        $urandom_range(2000, 4095),
                                        $urandom_range(0, 4095),
                                        $urandom_range(0, 4095));
            endcase
            calm <= (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold off the sender until the pipeline is empty
                if (k == PHASE_ITEMS / 2) wait_for_results(1);
                send_random_request();
            end
        end
        calm <= 1'b0;

        // Drain and let the block settle
        wait_for_results(SETTLE_CYCLES);

        $display("Sent %0d requests (%0d recenters) across %0d register settings.",
                 sb.requests, sb.recenters, NUM_PHASES + 1);
        $display("Checked %0d results, %0d searches ended at a peak, %0d mismatches.",
                 sb.results, sb.peaks, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
